### src/lms_pkg.sv
// LED mode sequencer package: mode and item kind codes, register indexes,
// register reset values and timing constants.
// No dependencies.
`timescale 1ns / 1ps

package lms_pkg;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_BLINK = 2'd1,
    MODE_FIXED = 2'd2,
    MODE_FADE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_MODE  = 2'd1,
    KIND_LEVEL = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_HALF_PERIOD = 3'd0,
    REG_REPEATS     = 3'd1,
    REG_CEILING     = 3'd2,
    REG_FLOOR       = 3'd3,
    REG_FALLBACK    = 3'd4
  } reg_index_t;

  localparam int unsigned CFG_W = 16;

  localparam logic [7:0]  LOOP_PERIOD_MS   = 8'd10;
  localparam logic [7:0]  FADE_STEP        = 8'd7;
  localparam logic [31:0] ELAPSED_MAX      = 32'hFFFF_FFFF;

  localparam logic [15:0] HALF_PERIOD_RST  = 16'd250;
  localparam logic [7:0]  REPEATS_RST      = 8'd5;
  localparam logic [7:0]  CEILING_RST      = 8'd255;
  localparam logic [7:0]  FLOOR_RST        = 8'd0;
  localparam logic [7:0]  LEVEL_RST        = 8'd255;

  typedef struct packed {
    logic       led_on;
    logic [7:0] brightness;
    mode_t      mode;
  } result_t;

endpackage

### src/led_mode_sequencer_unit.sv
// LED mode sequencer top level: tick, mode request and brightness items in,
// one status item out per input item. Uses lms_pkg.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: kind; tdata: mode_value, brightness_value
// m_*       out  m_tvalid/m_tready  tdata: led_on, brightness, mode
// cfg_*     in   cfg_wr_en          cfg_index, cfg_data
//
// One item per cycle while s_tready is high; its result is registered in m_tdata, or in
// the skid register while the sink stalls. A two-entry output stage (result register and
// skid register) lets input run while the sink stalls. A write to the half period register
// starts a one-bit-per-cycle division of the time in mode; s_tready is low meanwhile.
// Reset is synchronous; no clearing pass follows it.

module led_mode_sequencer_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [15:0]              s_tdata,   // [1:0] mode_value, [9:2] brightness_value
  input  logic [1:0]               s_tuser,   // [1:0] kind
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [15:0]              m_tdata,   // [0] led_on, [8:1] brightness, [10:9] mode
  input  logic                     cfg_wr_en,
  input  logic [2:0]               cfg_index,
  input  logic [lms_pkg::CFG_W-1:0] cfg_data
);

  logic [15:0]   half_period;
  logic [7:0]    repeats;
  logic [7:0]    ceiling;
  logic [7:0]    floor_level;
  lms_pkg::mode_t fallback;

  lms_pkg::mode_t current_mode, current_mode_next;
  lms_pkg::mode_t wanted_mode, wanted_mode_next;
  logic [31:0]   elapsed, elapsed_next;
  logic [7:0]    loop_divider, loop_divider_next;
  logic          lamp_on, lamp_on_next;
  logic [7:0]    level, level_next;
  logic          fading_up, fading_up_next;
  logic [15:0]   phase_rem, phase_rem_next;
  logic          phase_odd, phase_odd_next;

  logic          div_busy;
  logic [4:0]    div_count;
  logic [31:0]   div_dvd;
  logic [15:0]   div_rem;
  logic [16:0]   div_shift;
  logic          div_ge;
  logic [16:0]   div_rem_next;

  lms_pkg::result_t out_data, skid_data, new_data;
  logic          skid_valid;

  logic          accept;
  logic          out_free;
  logic [15:0]   half_eff;
  logic [23:0]   blink_total;
  logic [16:0]   rem_inc;
  logic [8:0]    fade_val;
  lms_pkg::mode_t eval_mode;

  assign half_eff    = (half_period == 16'd0) ? 16'd1 : half_period;
  assign blink_total = {16'd0, repeats} * {8'd0, half_period};
  assign accept      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = !skid_valid && !div_busy;

  assign m_tdata = {5'd0, out_data.mode, out_data.brightness, out_data.led_on};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= lms_pkg::HALF_PERIOD_RST;
      repeats     <= lms_pkg::REPEATS_RST;
      ceiling     <= lms_pkg::CEILING_RST;
      floor_level <= lms_pkg::FLOOR_RST;
      fallback    <= lms_pkg::MODE_OFF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lms_pkg::REG_HALF_PERIOD: half_period <= cfg_data[15:0];
        lms_pkg::REG_REPEATS:     repeats     <= cfg_data[7:0];
        lms_pkg::REG_CEILING:     ceiling     <= cfg_data[7:0];
        lms_pkg::REG_FLOOR:       floor_level <= cfg_data[7:0];
        lms_pkg::REG_FALLBACK:    fallback    <= lms_pkg::mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // restoring division step: rebuild half period phase after a period change
  assign div_shift    = {div_rem, div_dvd[31]};
  assign div_ge       = div_shift >= {1'b0, half_eff};
  assign div_rem_next = div_ge ? (div_shift - {1'b0, half_eff}) : div_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy  <= 1'b0;
      div_count <= 5'd0;
    end else if (cfg_wr_en && (cfg_index == lms_pkg::REG_HALF_PERIOD)) begin
      div_busy  <= 1'b1;
      div_count <= 5'd0;
    end else if (div_busy) begin
      div_count <= div_count + 5'd1;
      if (div_count == 5'd31) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_wr_en && (cfg_index == lms_pkg::REG_HALF_PERIOD)) begin
      div_dvd <= elapsed;
      div_rem <= 16'd0;
    end else if (div_busy) begin
      div_dvd <= {div_dvd[30:0], div_ge};
      div_rem <= div_rem_next[15:0];
    end
  end

  // item processing
  always_comb begin
    current_mode_next = current_mode;
    wanted_mode_next  = wanted_mode;
    elapsed_next      = elapsed;
    loop_divider_next = loop_divider;
    lamp_on_next      = lamp_on;
    level_next        = level;
    fading_up_next    = fading_up;
    phase_rem_next    = phase_rem;
    phase_odd_next    = phase_odd;
    eval_mode         = current_mode;
    fade_val          = {1'b0, level};
    rem_inc           = {1'b0, phase_rem} + 17'd1;

    unique case (lms_pkg::kind_t'(s_tuser))
      lms_pkg::KIND_TICK: begin
        if (elapsed != lms_pkg::ELAPSED_MAX) begin
          elapsed_next = elapsed + 32'd1;
          if (rem_inc == {1'b0, half_eff}) begin
            phase_rem_next = 16'd0;
            phase_odd_next = !phase_odd;
          end else begin
            phase_rem_next = rem_inc[15:0];
          end
        end
        loop_divider_next = loop_divider + 8'd1;
        if (loop_divider_next >= lms_pkg::LOOP_PERIOD_MS) begin
          loop_divider_next = 8'd0;
          unique case (current_mode)
            lms_pkg::MODE_OFF: begin
              lamp_on_next = 1'b0;
              eval_mode    = wanted_mode;
            end
            lms_pkg::MODE_BLINK: begin
              if (elapsed_next > {8'd0, blink_total}) begin
                wanted_mode_next = fallback;
                lamp_on_next     = 1'b0;
                eval_mode        = lms_pkg::MODE_OFF;
              end else begin
                lamp_on_next = !phase_odd_next;
                eval_mode    = lms_pkg::MODE_BLINK;
              end
            end
            lms_pkg::MODE_FIXED: begin
              lamp_on_next = 1'b1;
              eval_mode    = wanted_mode;
            end
            lms_pkg::MODE_FADE: begin
              if (fading_up) begin
                if (level < ceiling) begin
                  fade_val = {1'b0, level} + {1'b0, lms_pkg::FADE_STEP};
                end else begin
                  fading_up_next = 1'b0;
                end
              end else begin
                if (level > floor_level) begin
                  fade_val = (level >= lms_pkg::FADE_STEP) ?
                             {1'b0, level - lms_pkg::FADE_STEP} : 9'd0;
                end else begin
                  fading_up_next = 1'b1;
                end
              end
              if (fade_val > {1'b0, ceiling}) begin
                fade_val = {1'b0, ceiling};
              end
              if (fade_val < {1'b0, floor_level}) begin
                fade_val = {1'b0, floor_level};
              end
              level_next   = fade_val[7:0];
              lamp_on_next = 1'b1;
              eval_mode    = wanted_mode;
            end
            default: ;
          endcase
          if (eval_mode != current_mode) begin
            current_mode_next = eval_mode;
            elapsed_next      = 32'd0;
            phase_rem_next    = 16'd0;
            phase_odd_next    = 1'b0;
          end
        end
      end
      lms_pkg::KIND_MODE:  wanted_mode_next = lms_pkg::mode_t'(s_tdata[1:0]);
      lms_pkg::KIND_LEVEL: level_next = s_tdata[9:2];
      default: ;
    endcase

    new_data.led_on     = lamp_on_next;
    new_data.brightness = level_next;
    new_data.mode       = current_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= lms_pkg::MODE_OFF;
      wanted_mode  <= lms_pkg::MODE_OFF;
      elapsed      <= 32'd0;
      loop_divider <= 8'd0;
      lamp_on      <= 1'b0;
      level        <= lms_pkg::LEVEL_RST;
      fading_up    <= 1'b1;
      phase_rem    <= 16'd0;
      phase_odd    <= 1'b0;
    end else if (accept) begin
      current_mode <= current_mode_next;
      wanted_mode  <= wanted_mode_next;
      elapsed      <= elapsed_next;
      loop_divider <= loop_divider_next;
      lamp_on      <= lamp_on_next;
      level        <= level_next;
      fading_up    <= fading_up_next;
      phase_rem    <= phase_rem_next;
      phase_odd    <= phase_odd_next;
    end else if (div_busy && (div_count == 5'd31)) begin
      phase_rem <= div_rem_next[15:0];
      phase_odd <= div_ge;
    end
  end

  // result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= new_data;
      end
    end else if (accept) begin
      skid_data <= new_data;
    end
  end

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register holds an item while result register is empty");

  a_no_take_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !s_tready)
    else $error("item taken during phase rebuild");

  a_mode_change_clears_time: assert property (@(posedge clk) disable iff (rst)
    (current_mode != $past(current_mode)) |-> (elapsed == 32'd0))
    else $error("mode changed without restarting time in mode");

  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    !div_busy |-> (phase_rem < half_eff))
    else $error("half period phase out of range");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for led_mode_sequencer_unit: a directed table, then random
// tick, mode, brightness and none items over several register settings, each result checked.
// Depends on lms_pkg and led_mode_sequencer_unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int RAND_PER_PHASE = 205;
  localparam int PHASES         = 6;
  localparam int LONG_HOLD      = 200;
  localparam int STALL_LIMIT    = 5000;
  localparam int SCRIPT_LEN     = 25;

  typedef struct packed {
    lms_pkg::kind_t   k;
    logic [1:0]       mv;
    logic [7:0]       br;
    logic             typed;
    lms_pkg::result_t want;
  } row_t;

  localparam lms_pkg::result_t NO_WANT   = '0;
  localparam lms_pkg::result_t DARK_FULL = '{1'b0, 8'hFF, lms_pkg::MODE_OFF};

  localparam row_t SCRIPT [SCRIPT_LEN] = '{
    '{lms_pkg::KIND_NONE,  2'd3, 8'hFF, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_LEVEL, 2'd1, 8'h00, 1'b1, '{1'b0, 8'h00, lms_pkg::MODE_OFF}},
    '{lms_pkg::KIND_LEVEL, 2'd2, 8'hFF, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_MODE,  lms_pkg::MODE_FADE, 8'h55, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, DARK_FULL},
    '{lms_pkg::KIND_TICK,  2'd0, 8'h00, 1'b1, '{1'b0, 8'hFF, lms_pkg::MODE_FADE}},
    '{lms_pkg::KIND_MODE,  lms_pkg::MODE_BLINK, 8'hAA, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT},
    '{lms_pkg::KIND_TICK,  2'd3, 8'hFF, 1'b0, NO_WANT}
  };

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [15:0]               s_tdata;   // [1:0] mode_value, [9:2] brightness_value
  logic [1:0]                s_tuser;   // [1:0] kind
  logic                      m_tvalid;
  logic                      m_tready;
  logic [15:0]               m_tdata;   // [0] led_on, [8:1] brightness, [10:9] mode
  logic                      cfg_wr_en;
  logic [2:0]                cfg_index;
  logic [lms_pkg::CFG_W-1:0] cfg_data;

  // predictor state and register copies
  lms_pkg::mode_t cur_mode;
  lms_pkg::mode_t req_mode;
  logic [31:0]    ms_in_mode;
  logic [7:0]     tick_div;
  logic           lamp;
  logic [7:0]     lvl;
  logic           rising;
  logic [15:0]    half_ms;
  logic [7:0]     repeats;
  logic [7:0]     ceil_lvl;
  logic [7:0]     floor_lvl;
  lms_pkg::mode_t fallback;

  lms_pkg::result_t pending_status [$];
  int      mismatches   = 0;
  int      items_sent   = 0;
  int      results_seen = 0;
  int      blink_ends   = 0;
  int      fade_turns   = 0;
  int      send_idle    = 0;
  int      recv_idle    = 0;
  int      long_hold_req = 0;
  int      stall_cycles = 0;

  led_mode_sequencer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_lamp_state();
    cur_mode   = lms_pkg::MODE_OFF;
    req_mode   = lms_pkg::MODE_OFF;
    ms_in_mode = '0;
    tick_div   = '0;
    lamp       = 1'b0;
    lvl        = lms_pkg::LEVEL_RST;
    rising     = 1'b1;
    half_ms    = lms_pkg::HALF_PERIOD_RST;
    repeats    = lms_pkg::REPEATS_RST;
    ceil_lvl   = lms_pkg::CEILING_RST;
    floor_lvl  = lms_pkg::FLOOR_RST;
    fallback   = lms_pkg::MODE_OFF;
  endfunction

  function automatic lms_pkg::result_t advance_lamp(lms_pkg::kind_t k, logic [1:0] mv,
                                                    logic [7:0] br);
    lms_pkg::mode_t nxt;
    logic [31:0]    span;
    logic [31:0]    quot;
    int unsigned    v;
    case (k)
      lms_pkg::KIND_TICK: begin
        if (ms_in_mode != lms_pkg::ELAPSED_MAX) ms_in_mode = ms_in_mode + 1;
        tick_div = tick_div + 8'd1;
        if (tick_div >= lms_pkg::LOOP_PERIOD_MS) begin
          tick_div = '0;
          nxt = req_mode;
          case (cur_mode)
            lms_pkg::MODE_OFF: lamp = 1'b0;
            lms_pkg::MODE_FIXED: lamp = 1'b1;
            lms_pkg::MODE_BLINK: begin
              span = {24'd0, repeats} * {16'd0, half_ms};
              // a zero half period divides as one
              quot = ms_in_mode / ((half_ms == 16'd0) ? 32'd1 : {16'd0, half_ms});
              if (ms_in_mode > span) begin
                req_mode = fallback;
                lamp = 1'b0;
                nxt = lms_pkg::MODE_OFF;
                blink_ends++;
              end else begin
                lamp = ~quot[0];
                nxt = lms_pkg::MODE_BLINK;
              end
            end
            default: begin
              v = lvl;
              if (rising) begin
                if (v < ceil_lvl) v = v + lms_pkg::FADE_STEP;
                else begin
                  rising = 1'b0;
                  fade_turns++;
                end
              end else begin
                if (v > floor_lvl) v = (v >= lms_pkg::FADE_STEP) ? v - lms_pkg::FADE_STEP : 0;
                else begin
                  rising = 1'b1;
                  fade_turns++;
                end
              end
              // clamp to the ceiling first so the floor wins when they cross
              if (v > ceil_lvl) v = ceil_lvl;
              if (v < floor_lvl) v = floor_lvl;
              lvl = v[7:0];
              lamp = 1'b1;
            end
          endcase
          if (nxt != cur_mode) begin
            cur_mode = nxt;
            ms_in_mode = '0;
          end
        end
      end
      lms_pkg::KIND_MODE:  req_mode = lms_pkg::mode_t'(mv);
      lms_pkg::KIND_LEVEL: lvl = br;
      default: ;
    endcase
    return '{lamp, lvl, cur_mode};
  endfunction

  task automatic send_item(input lms_pkg::kind_t k, input logic [1:0] mv,
                           input logic [7:0] br, input logic typed,
                           input lms_pkg::result_t want);
    lms_pkg::result_t got;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {6'd0, br, mv};
    do @(posedge clk); while (!s_tready);
    got = advance_lamp(k, mv, br);
    pending_status.push_back(typed ? want : got);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input lms_pkg::reg_index_t idx,
                         input logic [lms_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      lms_pkg::REG_HALF_PERIOD: half_ms   = val;
      lms_pkg::REG_REPEATS:     repeats   = val[7:0];
      lms_pkg::REG_CEILING:     ceil_lvl  = val[7:0];
      lms_pkg::REG_FLOOR:       floor_lvl = val[7:0];
      lms_pkg::REG_FALLBACK:    fallback  = lms_pkg::mode_t'(val[1:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] half, input logic [7:0] rep,
                              input logic [7:0] ceil_v, input logic [7:0] floor_v,
                              input lms_pkg::mode_t fb);
    put_reg(lms_pkg::REG_HALF_PERIOD, half);
    put_reg(lms_pkg::REG_REPEATS, {8'd0, rep});
    put_reg(lms_pkg::REG_CEILING, {8'd0, ceil_v});
    put_reg(lms_pkg::REG_FLOOR, {8'd0, floor_v});
    put_reg(lms_pkg::REG_FALLBACK, {14'd0, fb});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req != 0) begin
        hold_left = LONG_HOLD;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    lms_pkg::result_t got;
    lms_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got.led_on     = m_tdata[0];
      got.brightness = m_tdata[8:1];
      got.mode       = lms_pkg::mode_t'(m_tdata[10:9]);
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, got led %0d level %0d mode %0d",
                 $time, got.led_on, got.brightness, got.mode);
      end else begin
        want = pending_status[0];
        pending_status.delete(0);
        check_field("led_on", want.led_on, got.led_on);
        check_field("brightness", want.brightness, got.brightness);
        check_field("mode", want.mode, got.mode);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int             ph;
    int             n;
    int             pick;
    lms_pkg::kind_t k;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = lms_pkg::KIND_TICK;
    cfg_wr_en = 1'b0;
    cfg_index = lms_pkg::REG_HALF_PERIOD;
    cfg_data  = '0;
    clear_lamp_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 2) begin
        send_idle = 18;
        recv_idle = 48;
      end else if (ph < 4) begin
        send_idle = 48;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (ph > 0) begin
        drain();
        case (ph)
          1: program_regs(16'd1, 8'd255, 8'd0, 8'd0, lms_pkg::MODE_BLINK);
          2: program_regs(16'hFFFF, 8'd0, 8'd255, 8'd255, lms_pkg::MODE_FADE);
          3: program_regs(16'd0, 8'd3, 8'd100, 8'd200, lms_pkg::MODE_FIXED);
          4: program_regs(16'd7, 8'd4, 8'd200, 8'd30, lms_pkg::MODE_OFF);
          default: program_regs(16'($urandom_range(40, 1)), 8'($urandom_range(12)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)),
                                 lms_pkg::mode_t'($urandom_range(3)));
        endcase
      end
      if (ph == 0) begin
        for (n = 0; n < SCRIPT_LEN; n++)
          send_item(SCRIPT[n].k, SCRIPT[n].mv, SCRIPT[n].br, SCRIPT[n].typed,
                    SCRIPT[n].want);
      end
      for (n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 4 && n == 40) long_hold_req = 1;
        if (ph == 3 && n == 100) drain();
        pick = $urandom_range(99);
        if (pick < 72)      k = lms_pkg::KIND_TICK;
        else if (pick < 85) k = lms_pkg::KIND_MODE;
        else if (pick < 95) k = lms_pkg::KIND_LEVEL;
        else                k = lms_pkg::KIND_NONE;
        send_item(k, 2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, NO_WANT);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("run covered %0d items over %0d register settings, %0d results checked",
             items_sent, PHASES, results_seen);
    $display("blink timeouts %0d, fade reversals %0d, mismatches %0d",
             blink_ends, fade_turns, mismatches);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
